/* hdl/bba_pkg.sv */
`default_nettype none

package bba_pkg;

    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_IDX_W     = 5;
    localparam int USE_W         = 9;

    localparam logic [USE_W-1:0] USE_MAX = 9'd511;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_HEADER  = 1'b0;
    localparam logic CFG_RESERVE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_PAGE   = 2'd2;

    localparam logic [6:0]  HEADER_RESET  = 7'd24;
    localparam logic [12:0] RESERVE_RESET = 13'd192;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;

    typedef struct packed {
        logic                 found;
        logic [MAP_IDX_W-1:0] index;
    } scan_t;

    typedef struct packed {
        logic      en;
        map_word_t mask;
        map_word_t data;
    } map_wr_t;

endpackage

`default_nettype wire

/* hdl/bba_scan.sv */
`default_nettype none

module bba_scan
    import bba_pkg::*;
(
    input  map_word_t word,
    output scan_t     result
);

    // lowest set bit of one free-map word
    always_comb
    begin
        result.found = |word;
        result.index = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                result.index = MAP_IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/bba_map_ram.sv */
`default_nettype none

module bba_map_ram
    import bba_pkg::*;
#(
    parameter int ROWS  = 80,
    parameter int ROW_W = 7
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [ROW_W-1:0] rd_row,
    output map_word_t        rd_data,
    input  map_wr_t          wr,
    input  logic [ROW_W-1:0] wr_row
);

    map_word_t mem [ROWS];

    // bit-masked write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int i = 0; i < MAP_WORD_BITS; i++)
            begin
                if (wr.mask[i])
                begin
                    mem[wr_row][i] <= wr.data[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_row];
        end
    end

endmodule

`default_nettype wire

/* hdl/buddy_block_allocator_top.sv */
`default_nettype none

// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | operation, request_size, block_address
// out     | output    | out_valid/out_stall| granted_address, status, page_released,
//         |           |                    | released_page
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one item at a time; the free-map memory port and the word scan set the pace.
// allocate: scans free-map words (a word of a closed page is skipped without a read; up to
// PAGE_COUNT x rows per page words over the orders searched), then splits one level at a
// time; on a new page it probes pages one by one and then reserves orders.
// free: merges one level at a time; when a page is released its rows per page (20) are cleared.
// after reset a clearing pass over PAGE_COUNT x rows-per-page rows (80) runs before
// the first item is taken; a result waiting on out_stall holds the next result back.

module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int PAGE_COUNT      = 4,
    parameter int PAGE_BYTES      = 8192,
    parameter int MIN_BLOCK_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [13:0] request_size,
    input  logic [14:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] granted_address,
    output logic [1:0]  status,
    output logic        page_released,
    output logic [1:0]  released_page,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int NBLK    = PAGE_BYTES / MIN_BLOCK_BYTES;
    localparam int TOP     = $clog2(NBLK);
    localparam int LOG_PB  = $clog2(PAGE_BYTES);
    localparam int LOG_MIN = $clog2(MIN_BLOCK_BYTES);
    localparam int ORD_W   = $clog2(TOP + 2);
    localparam int PG_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam bit FULL    = (NBLK >= MAP_WORD_BITS);
    localparam int W0      = FULL ? (NBLK / MAP_WORD_BITS) : 1;
    localparam int LOG_W0  = $clog2(W0);
    localparam int RPP     = FULL ? (2 * W0 - 1 + (TOP - LOG_W0)) : (TOP + 1);
    localparam int ROWS    = PAGE_COUNT * RPP;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int B_W     = ((TOP > MAP_IDX_W) ? TOP : MAP_IDX_W) + 1;
    localparam int WRD_W   = B_W - MAP_IDX_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SRCH_ADDR,
        S_SRCH_DATA,
        S_NEWPAGE,
        S_RESERVE,
        S_TAKE,
        S_SPLIT,
        S_GRANT,
        S_MERGE_ADDR,
        S_MERGE_DATA,
        S_MARK,
        S_COUNT,
        S_RELEASE,
        S_FINISH
    } state_t;

    function automatic logic [ORD_W-1:0] order_of(input logic [15:0] x);
        logic [ORD_W-1:0] r;
        r = ORD_W'(TOP + 1);
        for (int k = TOP; k >= 0; k--)
        begin
            if (18'(x) <= (18'(MIN_BLOCK_BYTES) << k))
            begin
                r = ORD_W'(k);
            end
        end
        return r;
    endfunction

    // first row of an order within a page
    function automatic logic [ROW_W-1:0] order_base(input logic [ORD_W-1:0] k);
        logic [ROW_W:0] r;
        if (!FULL)
        begin
            r = (ROW_W+1)'(k);
        end
        else if (k <= ORD_W'(LOG_W0 + 1))
        begin
            r = (ROW_W+1)'(2 * W0) - ((ROW_W+1)'(2 * W0) >> k);
        end
        else
        begin
            r = (ROW_W+1)'(2 * W0 - 1) + (ROW_W+1)'(k) - (ROW_W+1)'(LOG_W0 + 1);
        end
        return r[ROW_W-1:0];
    endfunction

    function automatic logic [WRD_W-1:0] last_word(input logic [ORD_W-1:0] k);
        logic [WRD_W-1:0] r;
        r = '0;
        if (FULL && (k <= ORD_W'(LOG_W0)))
        begin
            r = (WRD_W'(W0) >> k) - WRD_W'(1);
        end
        return r;
    endfunction

    state_t            state_reg;
    logic [ROW_W-1:0]  clr_cnt_reg;
    logic              op_reg;
    logic [14:0]       need_reg;
    logic [14:0]       addr_reg;
    logic [6:0]        header_reg;
    logic [12:0]       reserve_reg;
    logic [PG_W-1:0]   p_reg;
    logic [ORD_W-1:0]  k_reg;
    logic [ORD_W-1:0]  kn_reg;
    logic [ORD_W-1:0]  kr_reg;
    logic [WRD_W-1:0]  w_reg;
    logic [B_W-1:0]    b_reg;
    logic [PAGE_COUNT-1:0] page_open_reg;
    logic [USE_W-1:0]  use_cnt_reg [PAGE_COUNT];
    logic [14:0]       res_grant_reg;
    logic [1:0]        res_status_reg;
    logic              res_rel_reg;
    logic [1:0]        res_relp_reg;
    logic              out_valid_reg;
    logic [14:0]       out_grant_reg;
    logic [1:0]        out_status_reg;
    logic              out_rel_reg;
    logic [1:0]        out_relp_reg;

    logic [B_W-1:0]    addr_blk;
    logic [WRD_W-1:0]  word_sel;
    logic [MAP_IDX_W-1:0] bit_sel;
    logic [ROW_W-1:0]  page_row0;
    logic [ROW_W-1:0]  row_sel;
    logic              rd_en;
    map_word_t         rd_data;
    map_wr_t           wr;
    logic [ROW_W-1:0]  wr_row;
    scan_t             scan_res;

    logic              adv_done;
    logic [PG_W-1:0]   adv_p;
    logic [ORD_W-1:0]  adv_k;
    logic [WRD_W-1:0]  adv_w;

    logic [17:0]       pg_full;
    logic              free_ok;
    logic [ORD_W-1:0]  free_k;
    logic [B_W-1:0]    free_b;
    logic              too_large;
    logic [ORD_W-1:0]  need_order;
    logic [ORD_W-1:0]  rsv_order;
    logic [USE_W-1:0]  use_cur;
    logic              page_cur_open;
    logic [31:0]       grant_take;
    logic [31:0]       grant_page;

    assign in_stall        = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign granted_address = out_grant_reg;
    assign status          = out_status_reg;
    assign page_released   = out_rel_reg;
    assign released_page   = out_relp_reg;

    assign use_cur       = use_cnt_reg[p_reg];
    assign page_cur_open = page_open_reg[p_reg];
    assign need_order    = order_of(16'(need_reg));
    assign rsv_order     = order_of(16'(reserve_reg));
    assign too_large     = (18'(need_reg) + 18'(reserve_reg)) > 18'(PAGE_BYTES);

    assign pg_full = 18'(addr_reg) >> LOG_PB;
    assign free_ok = (pg_full < 18'(PAGE_COUNT)) && page_open_reg[PG_W'(pg_full)];
    assign free_k  = need_order;
    assign free_b  = B_W'((18'(addr_reg) & 18'(PAGE_BYTES - 1)) >> (LOG_MIN + int'(free_k)));

    assign grant_take = (32'(p_reg) << LOG_PB) + ((32'(b_reg) << k_reg) << LOG_MIN);
    assign grant_page = (32'(p_reg) << LOG_PB) + 32'(reserve_reg);

    // block whose map bit the current state touches
    always_comb
    begin
        unique case (state_reg)
            S_SPLIT:                    addr_blk = b_reg + B_W'(1);
            S_MERGE_ADDR, S_MERGE_DATA: addr_blk = b_reg ^ B_W'(1);
            S_RESERVE:                  addr_blk = B_W'(1);
            default:                    addr_blk = b_reg;
        endcase
    end

    assign word_sel  = ((state_reg == S_SRCH_ADDR) || (state_reg == S_SRCH_DATA))
                       ? w_reg : addr_blk[B_W-1:MAP_IDX_W];
    assign bit_sel   = addr_blk[MAP_IDX_W-1:0];
    assign page_row0 = ROW_W'(int'(p_reg) * RPP);
    assign row_sel   = page_row0 + order_base(k_reg) + ROW_W'(word_sel);

    // next word / page / order of the search
    always_comb
    begin
        adv_done = 1'b0;
        adv_p    = p_reg;
        adv_k    = k_reg;
        adv_w    = w_reg;
        priority if (w_reg != last_word(k_reg))
        begin
            adv_w = w_reg + WRD_W'(1);
        end
        else if (p_reg != PG_W'(PAGE_COUNT - 1))
        begin
            adv_p = p_reg + PG_W'(1);
            adv_w = '0;
        end
        else if (k_reg != ORD_W'(TOP))
        begin
            adv_k = k_reg + ORD_W'(1);
            adv_p = '0;
            adv_w = '0;
        end
        else
        begin
            adv_done = 1'b1;
            adv_p    = '0;
        end
    end

    always_comb
    begin
        rd_en   = ((state_reg == S_SRCH_ADDR) && page_cur_open)
                  || ((state_reg == S_MERGE_ADDR) && (k_reg < ORD_W'(TOP)));
        wr.en   = 1'b0;
        wr.mask = map_word_t'(1) << bit_sel;
        wr.data = '0;
        wr_row  = row_sel;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en   = 1'b1;
                wr.mask = '1;
                wr_row  = clr_cnt_reg;
            end
            S_RELEASE:
            begin
                wr.en   = 1'b1;
                wr.mask = '1;
                wr_row  = page_row0 + clr_cnt_reg;
            end
            S_TAKE:
            begin
                wr.en = 1'b1;
            end
            S_SPLIT, S_RESERVE, S_MARK:
            begin
                wr.en   = 1'b1;
                wr.data = '1;
            end
            S_MERGE_DATA:
            begin
                wr.en = rd_data[bit_sel];
            end
            default:
            begin
                wr.en = 1'b0;
            end
        endcase
    end

    bba_map_ram #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_map (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_row  (row_sel),
        .rd_data (rd_data),
        .wr      (wr),
        .wr_row  (wr_row)
    );

    bba_scan u_scan (
        .word   (rd_data),
        .result (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            page_open_reg <= '0;
            header_reg    <= HEADER_RESET;
            reserve_reg   <= RESERVE_RESET;
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                use_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HEADER:  header_reg  <= cfg_data[6:0];
                    CFG_RESERVE: reserve_reg <= cfg_data;
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
                    if (clr_cnt_reg == ROW_W'(ROWS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= operation;
                        need_reg       <= 15'(request_size) + 15'(header_reg);
                        addr_reg       <= block_address;
                        res_grant_reg  <= '0;
                        res_status_reg <= ST_OK;
                        res_rel_reg    <= 1'b0;
                        res_relp_reg   <= '0;
                        state_reg      <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if (too_large)
                        begin
                            res_status_reg <= ST_TOO_LARGE;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            kn_reg    <= need_order;
                            k_reg     <= need_order;
                            p_reg     <= '0;
                            w_reg     <= '0;
                            state_reg <= S_SRCH_ADDR;
                        end
                    end
                    else if (free_ok)
                    begin
                        p_reg     <= PG_W'(pg_full);
                        k_reg     <= free_k;
                        b_reg     <= free_b;
                        state_reg <= (free_k < ORD_W'(TOP)) ? S_MERGE_ADDR : S_COUNT;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_SRCH_ADDR:
                begin
                    if (page_cur_open)
                    begin
                        state_reg <= S_SRCH_DATA;
                    end
                    else
                    begin
                        p_reg     <= adv_p;
                        k_reg     <= adv_k;
                        w_reg     <= adv_w;
                        state_reg <= adv_done ? S_NEWPAGE : S_SRCH_ADDR;
                    end
                end
                S_SRCH_DATA:
                begin
                    if (scan_res.found)
                    begin
                        b_reg     <= (B_W'(w_reg) << MAP_IDX_W) | B_W'(scan_res.index);
                        state_reg <= S_TAKE;
                    end
                    else
                    begin
                        p_reg     <= adv_p;
                        k_reg     <= adv_k;
                        w_reg     <= adv_w;
                        state_reg <= adv_done ? S_NEWPAGE : S_SRCH_ADDR;
                    end
                end
                S_NEWPAGE:
                begin
                    if (!page_cur_open)
                    begin
                        if (kn_reg >= ORD_W'(TOP))
                        begin
                            page_open_reg[p_reg] <= 1'b1;
                            use_cnt_reg[p_reg]   <= USE_W'(1);
                            res_grant_reg        <= grant_page[14:0];
                            state_reg            <= S_FINISH;
                        end
                        else if (rsv_order >= ORD_W'(TOP))
                        begin
                            res_status_reg <= ST_NO_PAGE;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            page_open_reg[p_reg] <= 1'b1;
                            use_cnt_reg[p_reg]   <= '0;
                            k_reg                <= rsv_order;
                            kr_reg               <= rsv_order;
                            state_reg            <= S_RESERVE;
                        end
                    end
                    else if (p_reg == PG_W'(PAGE_COUNT - 1))
                    begin
                        res_status_reg <= ST_NO_PAGE;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        p_reg <= p_reg + PG_W'(1);
                    end
                end
                S_RESERVE:
                begin
                    if (k_reg == ORD_W'(TOP - 1))
                    begin
                        k_reg     <= (kn_reg > kr_reg) ? kn_reg : kr_reg;
                        b_reg     <= B_W'(1);
                        state_reg <= S_TAKE;
                    end
                    else
                    begin
                        k_reg <= k_reg + ORD_W'(1);
                    end
                end
                S_TAKE, S_SPLIT:
                begin
                    if (k_reg > kn_reg)
                    begin
                        k_reg     <= k_reg - ORD_W'(1);
                        b_reg     <= b_reg << 1;
                        state_reg <= S_SPLIT;
                    end
                    else
                    begin
                        state_reg <= S_GRANT;
                    end
                end
                S_GRANT:
                begin
                    if (use_cur < USE_MAX)
                    begin
                        use_cnt_reg[p_reg] <= use_cur + USE_W'(1);
                    end
                    res_grant_reg <= grant_take[14:0];
                    state_reg     <= S_FINISH;
                end
                S_MERGE_ADDR:
                begin
                    state_reg <= (k_reg < ORD_W'(TOP)) ? S_MERGE_DATA : S_MARK;
                end
                S_MERGE_DATA:
                begin
                    if (rd_data[bit_sel])
                    begin
                        b_reg     <= b_reg >> 1;
                        k_reg     <= k_reg + ORD_W'(1);
                        state_reg <= S_MERGE_ADDR;
                    end
                    else
                    begin
                        state_reg <= S_MARK;
                    end
                end
                S_MARK:
                begin
                    state_reg <= S_COUNT;
                end
                S_COUNT:
                begin
                    if (use_cur != '0)
                    begin
                        use_cnt_reg[p_reg] <= use_cur - USE_W'(1);
                        if (use_cur == USE_W'(1))
                        begin
                            page_open_reg[p_reg] <= 1'b0;
                            res_rel_reg          <= 1'b1;
                            res_relp_reg         <= 2'(p_reg);
                            clr_cnt_reg          <= '0;
                            state_reg            <= S_RELEASE;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_RELEASE:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
                    if (clr_cnt_reg == ROW_W'(RPP - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_grant_reg  <= res_grant_reg;
                        out_status_reg <= res_status_reg;
                        out_rel_reg    <= res_rel_reg;
                        out_relp_reg   <= res_relp_reg;
                        state_reg      <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sim/buddy_block_allocator_top_test.sv */
`timescale 1ns / 1ps

module buddy_block_allocator_top_test;
    import bba_pkg::*;

    localparam int NPAGE     = 4;
    localparam int PAGE_SZ   = 8192;
    localparam int MIN_BLK   = 32;
    localparam int NBLK      = PAGE_SZ / MIN_BLK;
    localparam int MAP_DEPTH = 2 * NBLK;
    localparam int TOP_K     = 8;

    typedef struct packed {
        logic [14:0] addr;
        logic [1:0]  st;
        logic        rel;
        logic [1:0]  relp;
    } grant_t;

    typedef struct {
        logic   op;
        int     size;
        int     addr;
        bit     typed;
        grant_t res;
    } row_t;

    typedef struct {
        int addr;
        int size;
    } live_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [13:0] request_size;
    logic [14:0] block_address;
    logic        out_valid;
    logic        out_stall;
    logic [14:0] granted_address;
    logic [1:0]  status;
    logic        page_released;
    logic [1:0]  released_page;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;

    bit          fmap [NPAGE][MAP_DEPTH];
    bit          popen [NPAGE];
    int unsigned puse [NPAGE];
    int unsigned hdr_bytes;
    int unsigned rsv_bytes;

    grant_t      grant_q [$];
    live_t       live_q [$];
    bit          cur_typed;
    grant_t      cur_res;
    bit          idle_on;
    int          errs;

    buddy_block_allocator_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .request_size(request_size),
        .block_address(block_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .granted_address(granted_address),
        .status(status),
        .page_released(page_released),
        .released_page(released_page),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int order_for(int unsigned x);
        int k;
        k = 0;
        while (k <= TOP_K && (MIN_BLK << k) < x) k++;
        return k;
    endfunction

    function automatic int midx(int k, int b);
        int base;
        base = 0;
        for (int j = 0; j < k; j++) base += NBLK >> j;
        return (base + b) % MAP_DEPTH;
    endfunction

    function automatic bit find_block(int kmin, output int fp, output int fk, output int fb);
        for (int k = kmin; k <= TOP_K; k++)
            for (int p = 0; p < NPAGE; p++)
            begin
                if (!popen[p]) continue;
                for (int b = 0; b < (NBLK >> k); b++)
                    if (fmap[p][midx(k, b)])
                    begin
                        fp = p;
                        fk = k;
                        fb = b;
                        return 1'b1;
                    end
            end
        return 1'b0;
    endfunction

    function automatic int take_block(int p, int k, int b, int kn);
        fmap[p][midx(k, b)] = 1'b0;
        while (k > kn)
        begin
            k--;
            b = b << 1;
            fmap[p][midx(k, b + 1)] = 1'b1;
        end
        if (puse[p] < 511) puse[p]++;
        return b * (MIN_BLK << kn);
    endfunction

    function automatic grant_t allocate_or_free(logic op, int unsigned size, int unsigned addr);
        grant_t r;
        int unsigned need;
        int unsigned g;
        int p, k, b, kn, kr;
        r = '0;
        g = 0;
        need = size + hdr_bytes;
        if (op == OP_ALLOC)
        begin
            if (need + rsv_bytes > PAGE_SZ)
                r.st = ST_TOO_LARGE;
            else
            begin
                kn = order_for(need);
                if (find_block(kn, p, k, b))
                    g = p * PAGE_SZ + take_block(p, k, b, kn);
                else
                begin
                    p = 0;
                    while (p < NPAGE && popen[p]) p++;
                    if (p >= NPAGE)
                        r.st = ST_NO_PAGE;
                    else if (kn >= TOP_K)
                    begin
                        popen[p] = 1'b1;
                        puse[p] = 1;
                        g = p * PAGE_SZ + rsv_bytes;
                    end
                    else
                    begin
                        kr = order_for(rsv_bytes);
                        if (kr >= TOP_K)
                            r.st = ST_NO_PAGE;
                        else
                        begin
                            popen[p] = 1'b1;
                            puse[p] = 0;
                            for (int j = kr; j < TOP_K; j++) fmap[p][midx(j, 1)] = 1'b1;
                            if (find_block(kn, p, k, b))
                                g = p * PAGE_SZ + take_block(p, k, b, kn);
                            else
                                r.st = ST_NO_PAGE;
                        end
                    end
                end
            end
            r.addr = g[14:0];
        end
        else
        begin
            p = addr / PAGE_SZ;
            if (p < NPAGE && popen[p])
            begin
                k = order_for(need);
                if (k < TOP_K)
                begin
                    b = (addr % PAGE_SZ) / (MIN_BLK << k);
                    while (k < TOP_K && fmap[p][midx(k, b ^ 1)])
                    begin
                        fmap[p][midx(k, b ^ 1)] = 1'b0;
                        b = b >> 1;
                        k++;
                    end
                    fmap[p][midx(k, b)] = 1'b1;
                end
                if (puse[p] > 0)
                begin
                    puse[p]--;
                    if (puse[p] == 0)
                    begin
                        for (int i = 0; i < MAP_DEPTH; i++) fmap[p][i] = 1'b0;
                        popen[p] = 1'b0;
                        r.rel = 1'b1;
                        r.relp = p[1:0];
                    end
                end
            end
        end
        return r;
    endfunction

    // result check first, then prediction for the word taken at the same edge
    always @(posedge clk)
    begin
        grant_t want;
        grant_t pred;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
            begin
                $error("result with nothing expected");
                errs++;
            end
            else
            begin
                want = grant_q.pop_front();
                if (granted_address !== want.addr)
                begin
                    $error("granted_address expected %0d actual %0d", want.addr, granted_address);
                    errs++;
                end
                if (status !== want.st)
                begin
                    $error("status expected %0d actual %0d", want.st, status);
                    errs++;
                end
                if (page_released !== want.rel)
                begin
                    $error("page_released expected %0d actual %0d", want.rel, page_released);
                    errs++;
                end
                if (released_page !== want.relp)
                begin
                    $error("released_page expected %0d actual %0d", want.relp, released_page);
                    errs++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            pred = allocate_or_free(operation, request_size, block_address);
            if (operation == OP_ALLOC && pred.st == ST_OK)
                live_q.push_back('{int'(pred.addr), int'(request_size)});
            grant_q.push_back(cur_typed ? cur_res : pred);
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(logic op, int size, int addr, bit typed, grant_t res);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        request_size  <= size[13:0];
        block_address <= addr[14:0];
        cur_typed     <= typed;
        cur_res       <= res;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        if (idx == CFG_HEADER)
            cfg_data <= 13'(val | ($urandom_range(0, 63) << 7));
        else
            cfg_data <= 13'(val);
        do @(posedge clk); while (!cfg_ready);
        if (cfg_index == CFG_HEADER)
            hdr_bytes = cfg_data & 13'h7F;
        else
            rsv_bytes = cfg_data;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_word;
        int sel;
        int size;
        int pick;
        live_t blk;
        sel = $urandom_range(0, 99);
        if (sel < 48)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7) size = $urandom_range(0, 300);
            else if (pick < 9) size = $urandom_range(0, 2000);
            else size = $urandom_range(0, 8192);
            send_word(OP_ALLOC, size, $urandom_range(0, 32767), 1'b0, '0);
        end
        else if (sel < 88 && live_q.size() != 0)
        begin
            pick = $urandom_range(0, live_q.size() - 1);
            blk = live_q[pick];
            live_q.delete(pick);
            send_word(OP_FREE, blk.size, blk.addr, 1'b0, '0);
        end
        else
            send_word(1'($urandom_range(0, 1)), $urandom_range(0, 16383),
                      $urandom_range(0, 32767), 1'b0, '0);
    endtask

    row_t rows [] = '{
        '{OP_FREE,      0,     0, 1, '{15'd0,     ST_OK,        1'b0, 2'd0}},
        '{OP_ALLOC,  8192,     0, 1, '{15'd0,     ST_TOO_LARGE, 1'b0, 2'd0}},
        '{OP_ALLOC, 16383, 32767, 1, '{15'd0,     ST_TOO_LARGE, 1'b0, 2'd0}},
        '{OP_ALLOC,     0,     0, 1, '{15'd256,   ST_OK,        1'b0, 2'd0}},
        '{OP_ALLOC,    40,     0, 0, '0},
        '{OP_ALLOC,  5000,     0, 1, '{15'd8384,  ST_OK,        1'b0, 2'd0}},
        '{OP_FREE,      0, 32767, 1, '{15'd0,     ST_OK,        1'b0, 2'd0}},
        '{OP_FREE,   5000,  8384, 1, '{15'd0,     ST_OK,        1'b1, 2'd1}},
        '{OP_FREE,     40,   320, 0, '0},
        '{OP_FREE,      0,   256, 1, '{15'd0,     ST_OK,        1'b1, 2'd0}},
        '{OP_FREE,      0,   256, 1, '{15'd0,     ST_OK,        1'b0, 2'd0}},
        '{OP_ALLOC,  5000,     0, 1, '{15'd192,   ST_OK,        1'b0, 2'd0}},
        '{OP_ALLOC,  5000,     0, 1, '{15'd8384,  ST_OK,        1'b0, 2'd0}},
        '{OP_ALLOC,  5000,     0, 1, '{15'd16576, ST_OK,        1'b0, 2'd0}},
        '{OP_ALLOC,  5000,     0, 1, '{15'd24768, ST_OK,        1'b0, 2'd0}},
        '{OP_ALLOC,  5000,     0, 1, '{15'd0,     ST_NO_PAGE,   1'b0, 2'd0}},
        '{OP_ALLOC,     0,     0, 1, '{15'd0,     ST_NO_PAGE,   1'b0, 2'd0}},
        '{OP_FREE,   5000,   192, 1, '{15'd0,     ST_OK,        1'b1, 2'd0}},
        '{OP_FREE,      0,  8200, 1, '{15'd0,     ST_OK,        1'b1, 2'd1}},
        '{OP_FREE,   5000, 16576, 1, '{15'd0,     ST_OK,        1'b1, 2'd2}},
        '{OP_FREE,   5000, 24768, 1, '{15'd0,     ST_OK,        1'b1, 2'd3}},
        '{OP_ALLOC,   100,     0, 0, '0},
        '{OP_FREE,    100,   256, 0, '0},
        '{OP_FREE,    100,   256, 0, '0}
    };

    int phase_hdr [] = '{0, 64, 0, 13, 24};
    int phase_rsv [] = '{0, 4096, 5000, 700, 192};

    initial
    begin
        errs          = 0;
        idle_on       = 1'b1;
        hdr_bytes     = HEADER_RESET;
        rsv_bytes     = RESERVE_RESET;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_ALLOC;
        request_size  = '0;
        block_address = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_HEADER;
        cfg_data      = '0;
        cur_typed     = 1'b0;
        cur_res       = '0;
        for (int p = 0; p < NPAGE; p++)
        begin
            popen[p] = 1'b0;
            puse[p]  = 0;
            for (int i = 0; i < MAP_DEPTH; i++) fmap[p][i] = 1'b0;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_word(rows[i].op, rows[i].size, rows[i].addr, rows[i].typed, rows[i].res);
        cur_typed <= 1'b0;

        foreach (phase_hdr[ph])
        begin
            drain();
            write_reg(CFG_HEADER, phase_hdr[ph]);
            write_reg(CFG_RESERVE, phase_rsv[ph]);
            live_q.delete();
            // last phase runs at full rate on both sides
            if (ph == phase_hdr.size() - 1)
                idle_on = 1'b0;
            repeat (ph == 2 ? 140 : 390) random_word();
        end

        in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errs == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
